>>> hw/rtl/ltc_pkg.sv
// Shared constants, keyword table and controller/datapath interface types.
package ltc_pkg;

    localparam int MAX_TOKEN  = 16;
    localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
    localparam int ADDR_W     = $clog2(MAX_TOKEN);
    localparam int CHAR_W     = 8;
    localparam int CLASS_W    = 3;
    localparam int NUM_KW     = 7;
    localparam int KW_SLOTS   = 8;
    localparam int KW_IDX_W   = $clog2(KW_SLOTS);

    typedef logic [CLASS_W-1:0] t_class;

    localparam t_class CLS_KEYWORD = 3'd0;
    localparam t_class CLS_IDENT   = 3'd1;
    localparam t_class CLS_OPER    = 3'd2;
    localparam t_class CLS_DELIM   = 3'd3;
    localparam t_class CLS_INT     = 3'd4;
    localparam t_class CLS_FLOAT   = 3'd5;

    // keyword spellings, zero padded
    localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [KW_IDX_W-1:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd2, 3'd6, 3'd4, 3'd4, 3'd6, 3'd3
    };

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input word taken this cycle
        logic read;        // fetch first stored character
        logic load_char;   // move fetched character to output register
        logic load_delim;  // move held delimiter to output register
        logic post;        // apply the held character after a flush
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic flush;       // accepted word ends a pending token
        logic hold;        // accepted word leaves a held character to apply
        logic hold_delim;  // held character is a delimiter
        logic last;        // character being loaded is the token's final one
        logic out_free;    // output register can take a word
    } t_dp_st;

endpackage

>>> hw/rtl/ltc_ram.sv
// Generic single-port-write, registered-read RAM.
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/ltc_ctrl.sv
// Sequencer: input acceptance, token replay and held-character handling.
module ltc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  ltc_pkg::t_dp_st  i_st,
    output ltc_pkg::t_dp_cmd o_cmd,
    output logic             o_s_tready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_POST,
        S_DELIM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.flush) begin
                        n_state = S_READ;
                    end else if (i_st.hold) begin
                        n_state = S_POST;
                    end
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_st.out_free) begin
                    o_cmd.load_char = 1'b1;
                    if (i_st.last) begin
                        n_state = S_POST;
                    end
                end
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = i_st.hold_delim ? S_DELIM : S_IDLE;
            end
            S_DELIM: begin
                if (i_st.out_free) begin
                    o_cmd.load_delim = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_ready;

endmodule

>>> hw/rtl/ltc_dp.sv
// Datapath: character classing, token store, keyword match and output register.
module ltc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ltc_pkg::t_dp_cmd              i_cmd,
    output ltc_pkg::t_dp_st               o_st,
    input  logic [ltc_pkg::CHAR_W-1:0]    i_text_byte,
    input  logic                          i_end_of_text,
    input  logic                          i_m_tready,
    output logic                          o_out_valid,
    output logic [ltc_pkg::CHAR_W-1:0]    o_out_char,
    output ltc_pkg::t_class               o_out_class,
    output logic                          o_out_last,
    output logic                          o_out_trunc
);

    typedef enum logic [2:0] {PH_IDLE, PH_WORD, PH_INT, PH_FRAC, PH_OP1} t_phase;
    typedef enum logic [2:0] {K_NONE, K_WORD, K_INT, K_OP, K_DELIM} t_kind;

    localparam logic [ltc_pkg::LEN_W-1:0] LEN_MAX = ltc_pkg::LEN_W'(ltc_pkg::MAX_TOKEN);
    localparam logic [ltc_pkg::CHAR_W-1:0] CH_DOT = 8'h2E;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == ">") || (c == "<") || (c == "=") || (c == "-") ||
               (c == "+") || (c == "*") || (c == "/");
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == "(") || (c == ")") || (c == ",") || (c == ";");
    endfunction

    // narrow the keyword candidates by the character at position pos
    function automatic logic [ltc_pkg::NUM_KW-1:0] kw_step(
        input logic [ltc_pkg::NUM_KW-1:0] prev,
        input logic [ltc_pkg::LEN_W-1:0]  pos,
        input logic [7:0]                 c
    );
        logic [ltc_pkg::NUM_KW-1:0] res;
        for (int w = 0; w < ltc_pkg::NUM_KW; w++) begin
            res[w] = prev[w] &&
                     (pos < ltc_pkg::LEN_W'(ltc_pkg::KW_LEN[w])) &&
                     (ltc_pkg::KW_TEXT[w][pos[ltc_pkg::KW_IDX_W-1:0]] == c);
        end
        return res;
    endfunction

    t_phase                         r_phase;
    logic [ltc_pkg::LEN_W-1:0]      r_len;
    logic                           r_ovf;
    logic [ltc_pkg::NUM_KW-1:0]     r_match;
    t_kind                          r_hold_kind;
    logic [ltc_pkg::CHAR_W-1:0]     r_hold_char;
    logic [ltc_pkg::LEN_W-1:0]      r_emit_len;
    logic [ltc_pkg::LEN_W-1:0]      r_ptr;
    ltc_pkg::t_class                r_cls;
    logic                           r_trunc;
    logic                           r_out_valid;
    logic [ltc_pkg::CHAR_W-1:0]     r_out_char;
    ltc_pkg::t_class                r_out_class;
    logic                           r_out_last;
    logic                           r_out_trunc;

    logic                           pending;
    logic                           absorb;
    logic                           pair;
    logic                           flush_now;
    logic                           can_put;
    t_kind                          kind;
    ltc_pkg::t_class                tok_class;
    logic [ltc_pkg::NUM_KW-1:0]     len_eq;
    logic                           kw_hit;
    logic [ltc_pkg::LEN_W-1:0]      ptr_plus;
    logic                           start_post;

    logic                           wr_en;
    logic [ltc_pkg::ADDR_W-1:0]     wr_addr;
    logic [ltc_pkg::CHAR_W-1:0]     wr_data;
    logic [ltc_pkg::ADDR_W-1:0]     rd_addr;
    logic [ltc_pkg::CHAR_W-1:0]     rd_data;

    assign pending = (r_phase != PH_IDLE);
    assign can_put = (r_len < LEN_MAX);

    assign absorb = !i_end_of_text && (
        ((r_phase == PH_WORD) && is_lower(i_text_byte)) ||
        ((r_phase == PH_INT)  && (is_digit(i_text_byte) || (i_text_byte == CH_DOT))) ||
        ((r_phase == PH_FRAC) && is_digit(i_text_byte)));
    assign pair      = !i_end_of_text && (r_phase == PH_OP1) && is_oper(i_text_byte);
    assign flush_now = pending && !absorb;

    always_comb begin
        kind = K_NONE;
        if (!i_end_of_text && !absorb && !pair) begin
            if (is_lower(i_text_byte)) begin
                kind = K_WORD;
            end else if (is_digit(i_text_byte)) begin
                kind = K_INT;
            end else if (is_oper(i_text_byte)) begin
                kind = K_OP;
            end else if (is_delim(i_text_byte)) begin
                kind = K_DELIM;
            end
        end
    end

    always_comb begin
        for (int w = 0; w < ltc_pkg::NUM_KW; w++) begin
            len_eq[w] = (r_len == ltc_pkg::LEN_W'(ltc_pkg::KW_LEN[w]));
        end
    end
    assign kw_hit = |(r_match & len_eq);

    always_comb begin
        case (r_phase)
            PH_WORD: tok_class = (!r_ovf && kw_hit) ? ltc_pkg::CLS_KEYWORD
                                                    : ltc_pkg::CLS_IDENT;
            PH_INT:  tok_class = ltc_pkg::CLS_INT;
            PH_FRAC: tok_class = ltc_pkg::CLS_FLOAT;
            default: tok_class = ltc_pkg::CLS_OPER;
        endcase
    end

    assign start_post = i_cmd.post &&
                        ((r_hold_kind == K_WORD) || (r_hold_kind == K_INT) ||
                         (r_hold_kind == K_OP));

    // store write: extend the pending token, or open a new one after a flush
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_len[ltc_pkg::ADDR_W-1:0];
        wr_data = i_text_byte;
        if (i_cmd.accept && (absorb || pair) && can_put) begin
            wr_en = 1'b1;
        end else if (start_post) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = r_hold_char;
        end
    end

    assign ptr_plus = r_ptr + 1'b1;
    assign rd_addr  = i_cmd.load_char ? ptr_plus[ltc_pkg::ADDR_W-1:0]
                                      : r_ptr[ltc_pkg::ADDR_W-1:0];

    ltc_ram #(
        .WIDTH (ltc_pkg::CHAR_W),
        .DEPTH (ltc_pkg::MAX_TOKEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.read | i_cmd.load_char),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_hold_kind <= K_NONE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_hold_kind <= kind;
                r_hold_char <= i_text_byte;
                if (absorb) begin
                    if (can_put) begin
                        r_len   <= r_len + 1'b1;
                        r_match <= kw_step(r_match, r_len, i_text_byte);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if ((r_phase == PH_INT) && (i_text_byte == CH_DOT)) begin
                        r_phase <= PH_FRAC;
                    end
                end
                if (flush_now) begin
                    r_emit_len <= pair ? r_len + 1'b1 : r_len;
                    r_cls      <= tok_class;
                    r_trunc    <= r_ovf;
                    r_ptr      <= '0;
                    r_phase    <= PH_IDLE;
                    r_len      <= '0;
                    r_ovf      <= 1'b0;
                end
            end

            if (start_post) begin
                r_len   <= ltc_pkg::LEN_W'(1);
                r_ovf   <= 1'b0;
                r_match <= kw_step('1, '0, r_hold_char);
                case (r_hold_kind)
                    K_WORD:  r_phase <= PH_WORD;
                    K_INT:   r_phase <= PH_INT;
                    default: r_phase <= PH_OP1;
                endcase
            end

            if (i_cmd.load_char) begin
                r_ptr       <= ptr_plus;
                r_out_valid <= 1'b1;
                r_out_char  <= rd_data;
                r_out_class <= r_cls;
                r_out_last  <= o_st.last;
                r_out_trunc <= r_trunc;
            end else if (i_cmd.load_delim) begin
                r_out_valid <= 1'b1;
                r_out_char  <= r_hold_char;
                r_out_class <= ltc_pkg::CLS_DELIM;
                r_out_last  <= 1'b1;
                r_out_trunc <= 1'b0;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_st.flush      = flush_now;
    assign o_st.hold       = (kind != K_NONE);
    assign o_st.hold_delim = (r_hold_kind == K_DELIM);
    assign o_st.last       = (ptr_plus == r_emit_len);
    assign o_st.out_free   = !r_out_valid || i_m_tready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_class = r_out_class;
    assign o_out_last  = r_out_last;
    assign o_out_trunc = r_out_trunc;

endmodule

>>> hw/rtl/lexical_token_classifier_core.sv
// Lexical token classifier: top level joining sequencer and datapath.
//
// Source text enters one byte per word on the slave side; tlast marks the end
// of text, which flushes the pending token and ignores tdata. Tokens leave on
// the master side one character per word, tlast on the final character and
// tuser carrying the class and a truncation flag. A byte that extends the
// pending token does not stall the input. A byte that ends a token holds the
// input through one store read to prime the registered RAM read, one load per
// character, one step to open the next token and one more to load a delimiter;
// master-side back-pressure stretches the character loads. A byte that opens a
// token with nothing pending skips the read and load steps. The single read
// port of the token store sets a replay rate of one character a cycle when
// the master side is ready. Tokens are held to 16 characters; further
// characters are dropped and every character of that token is flagged
// truncated, a cut-off letter run being an identifier. The output register
// lets a finished word wait on the master side while the next byte is taken.
module lexical_token_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // end_of_text
    // master side
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] token_char
    output logic       o_m_tlast,   // last_char
    output logic [3:0] o_m_tuser    // [2:0] token_class, [3] truncated
);

    ltc_pkg::t_dp_cmd cmd;
    ltc_pkg::t_dp_st  st;
    ltc_pkg::t_class  out_class;
    logic             out_trunc;

    ltc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready)
    );

    ltc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_text_byte   (i_s_tdata),
        .i_end_of_text (i_s_tlast),
        .i_m_tready    (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_out_char    (o_m_tdata),
        .o_out_class   (out_class),
        .o_out_last    (o_m_tlast),
        .o_out_trunc   (out_trunc)
    );

    assign o_m_tuser = {out_trunc, out_class};

endmodule

>>> hw/rtl/ltc_checker.sv
// Port-level checks for the token classifier, bound to the top level.
module ltc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [3:0] o_m_tuser
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[2:0] <= ltc_pkg::CLS_FLOAT))
        else $error("token class out of range");

    // delimiters are single, untruncated characters
    a_delim_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[2:0] == ltc_pkg::CLS_DELIM) |-> o_m_tlast && !o_m_tuser[3])
        else $error("delimiter word malformed");

    // a truncated letter run cannot be a keyword
    a_kw_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[2:0] == ltc_pkg::CLS_KEYWORD) |-> !o_m_tuser[3])
        else $error("keyword flagged truncated");

endmodule

bind lexical_token_classifier_core ltc_checker u_ltc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

>>> verif/lexical_token_classifier_core_test.sv
// Self-checking bench for the lexical token classifier: byte stream in, token characters out.
`timescale 1ns / 100ps

module lexical_token_classifier_core_test;

    // scanner state as the bench tracks it
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_OPER
    } t_scan;

    // one output word: a single token character
    typedef struct packed {
        ltc_pkg::t_class cls;
        logic [7:0]      ch;
        logic            last;
        logic            trunc;
    } t_tok_char;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the tokeniser state and holds the characters due
    // ------------------------------------------------------------------
    class token_scoreboard;
        t_tok_char   due_q[$];
        logic [7:0]  chars[ltc_pkg::MAX_TOKEN];
        int unsigned len;
        t_scan       phase;
        bit          ovf;
        int          mismatches;
        int          checked;
        int          tokens;
        int          cut_tokens;
        int          class_seen[6];

        function new();
            len = 0;
            phase = SCAN_IDLE;
            ovf = 1'b0;
        endfunction

        function bit is_lower(logic [7:0] c);
            return c >= "a" && c <= "z";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_oper(logic [7:0] c);
            return c == ">" || c == "<" || c == "=" || c == "-" || c == "+" ||
                   c == "*" || c == "/";
        endfunction

        function bit is_delim(logic [7:0] c);
            return c == "(" || c == ")" || c == "," || c == ";";
        endfunction

        function void append(logic [7:0] c);
            if (len < ltc_pkg::MAX_TOKEN) begin
                chars[len] = c;
                len++;
            end else begin
                ovf = 1'b1;
            end
        endfunction

        // letter runs: keyword only on an exact, uncut match
        function ltc_pkg::t_class letter_class();
            logic [47:0] spelled;
            int k;
            spelled = '0;
            if (ovf || len > 6)
                return ltc_pkg::CLS_IDENT;
            for (k = 0; k < len; k++)
                spelled = {spelled[39:0], chars[k]};
            case (spelled)
                "for", "if", "switch", "else", "case", "return", "int":
                    return ltc_pkg::CLS_KEYWORD;
                default: return ltc_pkg::CLS_IDENT;
            endcase
        endfunction

        function void push_char(ltc_pkg::t_class cls, logic [7:0] c, logic last, logic trunc);
            t_tok_char e;
            e.cls = cls;
            e.ch = c;
            e.last = last;
            e.trunc = trunc;
            due_q.push_back(e);
        endfunction

        // pending token leaves as one word per stored character
        function void emit_token();
            ltc_pkg::t_class cls;
            int k;
            if (phase != SCAN_IDLE && len > 0) begin
                case (phase)
                    SCAN_WORD: cls = letter_class();
                    SCAN_INT:  cls = ltc_pkg::CLS_INT;
                    SCAN_FRAC: cls = ltc_pkg::CLS_FLOAT;
                    default:   cls = ltc_pkg::CLS_OPER;
                endcase
                for (k = 0; k < len; k++)
                    push_char(cls, chars[k], k + 1 == len, ovf);
                tokens++;
                class_seen[cls]++;
                if (ovf)
                    cut_tokens++;
            end
            phase = SCAN_IDLE;
            len = 0;
            ovf = 1'b0;
        endfunction

        function void note_word(logic [7:0] c, logic eot);
            if (eot) begin
                emit_token();
                return;
            end
            case (phase)
                SCAN_WORD: if (is_lower(c)) begin
                    append(c);
                    return;
                end
                SCAN_INT: if (is_digit(c)) begin
                    append(c);
                    return;
                end else if (c == ".") begin
                    append(c);
                    phase = SCAN_FRAC;
                    return;
                end
                SCAN_FRAC: if (is_digit(c)) begin
                    append(c);
                    return;
                end
                SCAN_OPER: if (is_oper(c)) begin
                    append(c);
                    emit_token();
                    return;
                end
                default: ;
            endcase
            emit_token();
            if (is_lower(c)) begin
                phase = SCAN_WORD;
                append(c);
            end else if (is_digit(c)) begin
                phase = SCAN_INT;
                append(c);
            end else if (is_oper(c)) begin
                phase = SCAN_OPER;
                append(c);
            end else if (is_delim(c)) begin
                push_char(ltc_pkg::CLS_DELIM, c, 1'b1, 1'b0);
                tokens++;
                class_seen[ltc_pkg::CLS_DELIM]++;
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void check_word(logic [7:0] data, logic last, logic [3:0] user);
            t_tok_char e;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word char %02h last %0b class %0d trunc %0b",
                                 data, last, user[2:0], user[3]));
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (e.ch !== data || e.last !== last || e.cls !== user[2:0] ||
                e.trunc !== user[3])
                report($sformatf({"exp char %02h last %0b class %0d trunc %0b, ",
                                  "got char %02h last %0b class %0d trunc %0b"},
                                 e.ch, e.last, e.cls, e.trunc,
                                 data, last, user[2:0], user[3]));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [3:0] o_m_tuser;

    lexical_token_classifier_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    token_scoreboard sb = new();

    int    words_sent;
    int    calm_left;
    string keyword_list[7] = '{"for", "if", "switch", "else", "case", "return", "int"};
    string oper_chars      = "><=-+*/";
    string delim_chars     = "(),;";

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("[lexical_token_classifier_core] ERROR");
        $finish;
    end

    // Single monitor: the input word is noted before the output word is
    // checked, so same-edge ordering between the two sides cannot matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_word(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                sb.check_word(o_m_tdata, o_m_tlast, o_m_tuser);
        end
    end

    // Mostly short gaps, a few long ones, and occasional calm stretches
    // with no gaps at all.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_word(input logic [7:0] d, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_word(s[k], 1'b0);
    endtask

    task automatic send_letters(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word(8'("a" + $urandom_range(0, 25)), 1'b0);
    endtask

    task automatic send_digits(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
    endtask

    // one token-shaped chunk of random content, sometimes noise
    task automatic random_chunk();
        int kind;
        int n;
        int k;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: send_text(keyword_list[$urandom_range(0, 6)]);
            2, 3: send_letters($urandom_range(0, 5) == 0 ? $urandom_range(15, 20)
                                                         : $urandom_range(1, 8));
            4: send_letters($urandom_range(16, 17));
            5: send_digits($urandom_range(0, 5) == 0 ? $urandom_range(15, 19)
                                                     : $urandom_range(1, 5));
            6: begin
                send_digits($urandom_range(1, 4));
                send_word(".", 1'b0);
                send_digits($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    send_word(".", 1'b0);
            end
            7: begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    send_word(oper_chars[$urandom_range(0, 6)], 1'b0);
            end
            8: send_word(delim_chars[$urandom_range(0, 3)], 1'b0);
            9: send_word($urandom_range(0, 1) ? " " : 8'h0a, 1'b0);
            10: send_word(8'($urandom), 1'b1);
            default: send_word(8'($urandom_range(0, 255)), 1'(($urandom_range(0, 7) == 0)));
        endcase
    endtask

    // receiver: runs of ready broken by stalls of random length
    initial begin
        forever begin
            int stall;
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        int w;
        int leftover;
        int errors;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keyword, delimiters, identifier, lone digit, float cut
        // by a second dot, float ending on its dot, operator pair, single
        // operator ended by a letter, non-ASCII bytes, empty end marker,
        // end marker flushing a digit
        send_text("if(x,7;12.5.3.)>=+a");
        send_word(8'h80, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        send_word("9", 1'b0);
        send_word(8'hff, 1'b1);

        // random: mostly well-formed tokens, with separators and noise
        while (words_sent < 210) begin
            random_chunk();
            if ($urandom_range(0, 1))
                random_chunk();
            else
                send_word(" ", 1'b0);
        end
        send_word(8'h00, 1'b1);
        i_s_tvalid <= 1'b0;

        // drain, then allow for any stray trailing words
        for (w = 0; w < 20000 && sb.due_q.size() > 0; w++)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        leftover = sb.due_q.size();
        if (leftover > 0)
            $display("%0d expected characters never arrived", leftover);
        errors = sb.mismatches + leftover;

        $display("Sent %0d bytes; %0d tokens (%0d cut short) replayed as %0d characters.",
                 words_sent, sb.tokens, sb.cut_tokens, sb.checked);
        $display("By class: kw %0d, id %0d, op %0d, delim %0d, int %0d, float %0d.",
                 sb.class_seen[ltc_pkg::CLS_KEYWORD], sb.class_seen[ltc_pkg::CLS_IDENT],
                 sb.class_seen[ltc_pkg::CLS_OPER], sb.class_seen[ltc_pkg::CLS_DELIM],
                 sb.class_seen[ltc_pkg::CLS_INT], sb.class_seen[ltc_pkg::CLS_FLOAT]);
        if (errors == 0) begin
            $display("[lexical_token_classifier_core] OK");
        end else begin
            $display("[lexical_token_classifier_core] ERROR");
        end
        $finish;
    end

endmodule
